// ===== rtl/ddt_pkg.sv =====
// ----------------------------------------------------------------------------
// DDR delay tap trainer package
// Shared types, sizes and training patterns for the tap sweep.
// ----------------------------------------------------------------------------
`default_nettype none

package ddt_pkg;

    localparam int NUM_TAPS      = 16;
    localparam int READS_PER_TAP = 4;
    localparam int STROBE_GROUPS = 4;

    localparam int TAP_W   = 4;
    localparam int GROUP_W = 3;
    localparam int ADDR_W  = 6;
    localparam int WORD_W  = 32;
    localparam int NUM_WORDS = 4;
    localparam int RC_W    = (READS_PER_TAP > 1) ? $clog2(READS_PER_TAP) : 1;

    localparam logic [TAP_W-1:0]   TAP_MAX   = TAP_W'(NUM_TAPS - 1);
    localparam logic [GROUP_W-1:0] LAST_GRP  = GROUP_W'(STROBE_GROUPS);
    localparam logic [ADDR_W-1:0]  ADDR_EVEN = ADDR_W'(32);
    localparam logic [ADDR_W-1:0]  ADDR_ODD  = ADDR_W'(40);
    localparam logic [ADDR_W-1:0]  ADDR_NONE = '0;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] ALL_ZERO = 32'h0000_0000;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_words;

    localparam t_words PAT_EVEN = {ALL_ONES, ALL_ONES, ALL_ZERO, ALL_ZERO};
    localparam t_words PAT_ODD  = {ALL_ZERO, ALL_ONES, ALL_ZERO, ALL_ONES};

    typedef enum logic [1:0] {
        KIND_TRIAL   = 2'd0,
        KIND_SETTING = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [GROUP_W-1:0] group;
        logic [TAP_W-1:0]   tap_value;
        logic [ADDR_W-1:0]  read_address;
        logic               window_empty;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_pair;

endpackage

`default_nettype wire

// ===== rtl/ddt_sweep.sv =====
// ----------------------------------------------------------------------------
// DDR delay tap trainer sweep engine
// Holds the sweep state and turns one registered item into up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module ddt_sweep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic          i_action,
    input  wire ddt_pkg::t_words i_words,
    output ddt_pkg::t_pair     o_pair
);
    import ddt_pkg::*;

    logic               r_busy,      n_busy;
    logic [GROUP_W-1:0] r_cur_group, n_cur_group;
    logic [TAP_W-1:0]   r_cur_tap,   n_cur_tap;
    logic [RC_W-1:0]    r_read_cnt,  n_read_cnt;
    logic               r_tap_failed, n_tap_failed;
    logic [TAP_W-1:0]   r_win_low,   n_win_low;
    logic [TAP_W-1:0]   r_win_high,  n_win_high;

    t_words           pat;
    logic             fail;
    logic [RC_W:0]    rc_inc;
    logic [TAP_W-1:0] nl, nh;
    logic [TAP_W:0]   centre_sum;
    logic [TAP_W-1:0] setting;
    logic             empty;
    t_pair            pair;

    always_comb begin
        pat  = r_read_cnt[0] ? PAT_ODD : PAT_EVEN;
        fail = r_tap_failed;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (i_words[i] != pat[i]) begin
                fail = 1'b1;
            end
        end
        rc_inc = {1'b0, r_read_cnt} + 1'b1;
        nl = (!fail && r_cur_tap < r_win_low)  ? r_cur_tap : r_win_low;
        nh = (!fail && r_cur_tap > r_win_high) ? r_cur_tap : r_win_high;
        empty = nl > nh;
        centre_sum = {1'b0, nl} + {1'b0, nh} + 1'b1;
        if (r_cur_group == '0) begin
            setting = centre_sum[TAP_W:1];
        end else if (nl >= TAP_MAX) begin
            setting = TAP_MAX;
        end else begin
            setting = nl + 1'b1;
        end
    end

    always_comb begin
        n_busy       = r_busy;
        n_cur_group  = r_cur_group;
        n_cur_tap    = r_cur_tap;
        n_read_cnt   = r_read_cnt;
        n_tap_failed = r_tap_failed;
        n_win_low    = r_win_low;
        n_win_high   = r_win_high;
        pair         = '0;
        if (i_fire) begin
            if (i_action == ACT_START) begin
                n_busy       = 1'b1;
                n_cur_group  = '0;
                n_cur_tap    = '0;
                n_read_cnt   = '0;
                n_tap_failed = 1'b0;
                n_win_low    = TAP_MAX;
                n_win_high   = '0;
                pair.count   = 2'd1;
                pair.res0    = '{KIND_TRIAL, '0, '0, ADDR_EVEN, 1'b0, 1'b1};
            end else if (r_busy) begin
                if (rc_inc < (RC_W+1)'(READS_PER_TAP)) begin
                    n_read_cnt   = rc_inc[RC_W-1:0];
                    n_tap_failed = fail;
                    pair.count   = 2'd1;
                    pair.res0    = '{KIND_TRIAL, r_cur_group, r_cur_tap,
                                     rc_inc[0] ? ADDR_ODD : ADDR_EVEN, 1'b0, 1'b1};
                end else if (r_cur_tap < TAP_MAX) begin
                    n_win_low    = nl;
                    n_win_high   = nh;
                    n_cur_tap    = r_cur_tap + 1'b1;
                    n_read_cnt   = '0;
                    n_tap_failed = 1'b0;
                    pair.count   = 2'd1;
                    pair.res0    = '{KIND_TRIAL, r_cur_group, r_cur_tap + 1'b1,
                                     ADDR_EVEN, 1'b0, 1'b1};
                end else begin
                    n_cur_tap    = '0;
                    n_read_cnt   = '0;
                    n_tap_failed = 1'b0;
                    n_win_low    = TAP_MAX;
                    n_win_high   = '0;
                    pair.count   = 2'd2;
                    pair.res0    = '{KIND_SETTING, r_cur_group, setting,
                                     ADDR_NONE, empty, 1'b0};
                    if (r_cur_group < LAST_GRP) begin
                        n_cur_group = r_cur_group + 1'b1;
                        pair.res1   = '{KIND_TRIAL, r_cur_group + 1'b1, '0,
                                        ADDR_EVEN, 1'b0, 1'b1};
                    end else begin
                        n_busy      = 1'b0;
                        n_cur_group = '0;
                        pair.res1   = '{KIND_DONE, '0, '0, ADDR_NONE, 1'b0, 1'b1};
                    end
                end
            end
        end
    end

    assign o_pair = pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_cur_group  <= '0;
            r_cur_tap    <= '0;
            r_read_cnt   <= '0;
            r_tap_failed <= 1'b0;
            r_win_low    <= TAP_MAX;
            r_win_high   <= '0;
        end else begin
            r_busy       <= n_busy;
            r_cur_group  <= n_cur_group;
            r_cur_tap    <= n_cur_tap;
            r_read_cnt   <= n_read_cnt;
            r_tap_failed <= n_tap_failed;
            r_win_low    <= n_win_low;
            r_win_high   <= n_win_high;
        end
    end

    a_idle_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cur_group == '0 && r_cur_tap == '0 && r_read_cnt == '0))
        else $error("idle sweep not parked at group 0 tap 0");

    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pair.count == 2'd2 |-> (pair.res0.kind == KIND_SETTING && !pair.res0.last
                                && pair.res1.last))
        else $error("two-result item with wrong shape");

    a_idle_read_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_action == ACT_READ && !r_busy) |-> pair.count == 2'd0)
        else $error("read while idle produced a result");

endmodule

`default_nettype wire

// ===== rtl/ddt_out_buf.sv =====
// ----------------------------------------------------------------------------
// DDR delay tap trainer result buffer
// Two-slot result register; takes a result pair and hands results out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ddt_out_buf (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire ddt_pkg::t_pair i_pair,
    output logic              o_can_load,
    input  wire logic         i_load,
    output logic              o_valid,
    input  wire logic         i_ready,
    output ddt_pkg::t_result  o_result
);
    import ddt_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;

    assign o_valid    = r_cnt != 2'd0;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_result   = r_slot0;

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_load) begin
            n_cnt   = i_pair.count;
            n_slot0 = i_pair.res0;
            n_slot1 = i_pair.res1;
        end else if (o_valid && i_ready) begin
            n_cnt   = r_cnt - 1'b1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer overfilled");

    a_setting_has_follower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_slot0.kind == KIND_SETTING) |-> r_cnt == 2'd2)
        else $error("group setting without following result");

endmodule

`default_nettype wire

// ===== rtl/ddr_delay_tap_trainer.sv =====
// ----------------------------------------------------------------------------
// DDR delay tap trainer
// Sweeps the address group and four read strobes over all taps and reports
// trial taps, final group settings and completion.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): action 0 starts or restarts a sweep,
// action 1 carries the four words of one training read. Reads while idle are
// dropped without a result.
// Output channel (o_out_valid / i_out_ready): each result names the next trial
// tap and read address, a final group setting, or training done; o_last marks
// the last result of an input item.
// Path: an item is registered at its transfer and, once the result register
// can take it, processed into that two-slot result register, from which its
// first result is offered.
// Throughput: one input item per cycle while the output is not stalled and
// each item gives one result; an item that closes a group gives two results,
// and the next item waits until the first has left. The result register sets the rate.
// Reset: sweep state returns to idle, group 0, tap 0; both stages empty.
// Output stall: the result register and input register hold, and o_in_ready
// drops once the input register holds an item the result register cannot take.
// ----------------------------------------------------------------------------
`default_nettype none

module ddr_delay_tap_trainer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [31:0] i_word0,
    input  wire logic [31:0] i_word1,
    input  wire logic [31:0] i_word2,
    input  wire logic [31:0] i_word3,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_group,
    output logic [3:0]       o_tap_value,
    output logic [5:0]       o_read_address,
    output logic             o_window_empty,
    output logic             o_last
);
    import ddt_pkg::*;

    logic    r_in_valid;
    logic    r_action;
    t_words  r_words;
    logic    can_load;
    logic    advance;
    t_pair   pair;
    t_result result;

    assign advance    = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_action <= i_action;
            r_words  <= {i_word3, i_word2, i_word1, i_word0};
        end
    end

    ddt_sweep u_sweep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_action (r_action),
        .i_words  (r_words),
        .o_pair   (pair)
    );

    ddt_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pair     (pair),
        .o_can_load (can_load),
        .i_load     (advance),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (result)
    );

    assign o_kind         = result.kind;
    assign o_group        = result.group;
    assign o_tap_value    = result.tap_value;
    assign o_read_address = result.read_address;
    assign o_window_empty = result.window_empty;
    assign o_last         = result.last;

endmodule

`default_nettype wire

// ===== tb/ddr_delay_tap_trainer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDR delay tap trainer testbench
// Drives start and training-read transfers with random gaps and output
// stalls. A predictor of the tap sweep queues the expected trial, setting and
// done results. Each output transfer is checked field by field against it.
// ----------------------------------------------------------------------------

module ddr_delay_tap_trainer_tb;

    import ddt_pkg::*;

    typedef logic [3:0][31:0] t_read_words;

    typedef enum int {
        WIN_EMPTY,
        WIN_TOP_ONLY,
        WIN_BOTTOM_ONLY,
        WIN_FULL,
        WIN_SPAN,
        WIN_SCATTER
    } t_window_shape;

    localparam int          SWEEP_GROUPS      = 5;
    localparam int          SWEEP_TAPS        = 16;
    localparam int          TAP_READS         = 4;
    localparam logic [2:0]  LAST_STROBE_GROUP = 3'd4;
    localparam logic [3:0]  TOP_TAP           = 4'd15;
    localparam logic [5:0]  RD_ADDR_A         = 6'd32;
    localparam logic [5:0]  RD_ADDR_B         = 6'd40;
    localparam logic [5:0]  RD_ADDR_NONE      = 6'd0;
    localparam logic [31:0] WORD_ONES         = 32'hffff_ffff;
    localparam logic [31:0] WORD_ZERO         = 32'h0000_0000;
    localparam t_read_words PATTERN_A = {WORD_ONES, WORD_ONES, WORD_ZERO, WORD_ZERO};
    localparam t_read_words PATTERN_B = {WORD_ZERO, WORD_ONES, WORD_ZERO, WORD_ONES};

    localparam int TARGET_ITEMS    = 1650;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 6;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_action       = 1'b0;
    logic [31:0] i_word0        = '0;
    logic [31:0] i_word1        = '0;
    logic [31:0] i_word2        = '0;
    logic [31:0] i_word3        = '0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [2:0]  o_group;
    logic [3:0]  o_tap_value;
    logic [5:0]  o_read_address;
    logic        o_window_empty;
    logic        o_last;

    t_result     tap_results_due[$];
    int          failures        = 0;
    int          items_sent      = 0;
    int          idle_cycles     = 0;
    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;
    bit          hold_output     = 1'b0;

    logic        sweep_busy  = 1'b0;
    logic [2:0]  sweep_group = '0;
    logic [3:0]  sweep_tap   = '0;
    int          sweep_reads = 0;
    logic        tap_spoilt  = 1'b0;
    logic [3:0]  win_lo      = TOP_TAP;
    logic [3:0]  win_hi      = '0;

    ddr_delay_tap_trainer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_word0        (i_word0),
        .i_word1        (i_word1),
        .i_word2        (i_word2),
        .i_word3        (i_word3),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_group        (o_group),
        .o_tap_value    (o_tap_value),
        .o_read_address (o_read_address),
        .o_window_empty (o_window_empty),
        .o_last         (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void open_group(logic [2:0] g);
        sweep_group = g;
        sweep_tap   = '0;
        sweep_reads = 0;
        tap_spoilt  = 1'b0;
        win_lo      = TOP_TAP;
        win_hi      = '0;
    endfunction

    function automatic void expect_result(t_kind k, logic [2:0] g, logic [3:0] tap,
                                          logic [5:0] addr, logic empty, logic last);
        t_result r;
        r.kind         = k;
        r.group        = g;
        r.tap_value    = tap;
        r.read_address = addr;
        r.window_empty = empty;
        r.last         = last;
        tap_results_due.push_back(r);
    endfunction

    function automatic int predict_training_step(logic act, t_read_words w);
        t_read_words pat;
        int          setting;
        logic        empty;
        if (act == ACT_START) begin
            sweep_busy = 1'b1;
            open_group(3'd0);
            expect_result(KIND_TRIAL, 3'd0, 4'd0, RD_ADDR_A, 1'b0, 1'b1);
            return 1;
        end
        if (!sweep_busy) begin
            return 0;
        end
        pat = (sweep_reads % 2 == 1) ? PATTERN_B : PATTERN_A;
        if (w != pat) begin
            tap_spoilt = 1'b1;
        end
        sweep_reads++;
        if (sweep_reads < TAP_READS) begin
            expect_result(KIND_TRIAL, sweep_group, sweep_tap,
                          (sweep_reads % 2 == 1) ? RD_ADDR_B : RD_ADDR_A, 1'b0, 1'b1);
            return 1;
        end
        if (!tap_spoilt) begin
            if (sweep_tap < win_lo) begin
                win_lo = sweep_tap;
            end
            if (sweep_tap > win_hi) begin
                win_hi = sweep_tap;
            end
        end
        if (sweep_tap < TOP_TAP) begin
            sweep_tap   = sweep_tap + 4'd1;
            sweep_reads = 0;
            tap_spoilt  = 1'b0;
            expect_result(KIND_TRIAL, sweep_group, sweep_tap, RD_ADDR_A, 1'b0, 1'b1);
            return 1;
        end
        empty = (win_lo > win_hi);
        if (sweep_group == 3'd0) begin
            setting = (int'(win_lo) + int'(win_hi) + 1) >> 1;
        end else if (win_lo >= TOP_TAP) begin
            setting = int'(TOP_TAP);
        end else begin
            setting = int'(win_lo) + 1;
        end
        expect_result(KIND_SETTING, sweep_group, 4'(setting), RD_ADDR_NONE, empty, 1'b0);
        if (sweep_group < LAST_STROBE_GROUP) begin
            open_group(sweep_group + 3'd1);
            expect_result(KIND_TRIAL, sweep_group, 4'd0, RD_ADDR_A, 1'b0, 1'b1);
        end else begin
            sweep_busy = 1'b0;
            open_group(3'd0);
            expect_result(KIND_DONE, 3'd0, 4'd0, RD_ADDR_NONE, 1'b0, 1'b1);
        end
        return 2;
    endfunction

    function automatic int draw_gap(bit steady);
        return steady ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic t_read_words random_words();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic t_read_words spoil_words(t_read_words w);
        t_read_words s;
        int          wi;
        int          bi;
        s  = w;
        wi = $urandom_range(0, 3);
        bi = $urandom_range(0, 31);
        case ($urandom_range(0, 2))
            0: begin
                s[wi][bi] = ~s[wi][bi];
            end
            1: begin
                s[wi] = $urandom;
            end
            default: begin
                s = random_words();
            end
        endcase
        return s;
    endfunction

    function automatic logic [15:0] shape_mask(t_window_shape shape);
        logic [15:0] m;
        int          lo;
        int          hi;
        m  = '0;
        lo = $urandom_range(0, 15);
        hi = $urandom_range(lo, 15);
        case (shape)
            WIN_EMPTY:       m = '0;
            WIN_TOP_ONLY:    m[15] = 1'b1;
            WIN_BOTTOM_ONLY: m[0] = 1'b1;
            WIN_FULL:        m = '1;
            WIN_SPAN: begin
                for (int t = lo; t <= hi; t++) begin
                    m[t] = 1'b1;
                end
            end
            default:         m = 16'($urandom);
        endcase
        return m;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic send_item(input logic act, input t_read_words w);
        int gap;
        gap = draw_gap(sender_steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_word0    <= w[0];
        i_word1    <= w[1];
        i_word2    <= w[2];
        i_word3    <= w[3];
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (predict_training_step(act, w) != 0) begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tap_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_tap_reads(input bit pass);
        int          bad;
        t_read_words w;
        bad = $urandom_range(0, TAP_READS - 1);
        for (int r = 0; r < TAP_READS; r++) begin
            w = (r % 2 == 1) ? PATTERN_B : PATTERN_A;
            if (!pass && (r == bad || $urandom_range(0, 3) == 0)) begin
                w = spoil_words(w);
            end
            send_item(ACT_READ, w);
        end
    endtask

    task automatic sweep_training(input logic [4:0][15:0] masks, input int stop_taps);
        send_item(ACT_START, random_words());
        for (int g = 0; g < SWEEP_GROUPS; g++) begin
            for (int t = 0; t < SWEEP_TAPS; t++) begin
                if (g * SWEEP_TAPS + t >= stop_taps) begin
                    return;
                end
                send_tap_reads(masks[g][t]);
            end
        end
    endtask

    task automatic test_ignored_reads();
        send_item(ACT_READ, {4{WORD_ONES}});
        send_item(ACT_READ, {4{WORD_ZERO}});
        send_item(ACT_READ, random_words());
        wait_drained();
    endtask

    task automatic test_read_patterns();
        t_read_words w;
        send_item(ACT_START, {4{WORD_ONES}});
        send_item(ACT_READ, PATTERN_A);
        send_item(ACT_READ, {4{WORD_ONES}});
        send_item(ACT_READ, {4{WORD_ZERO}});
        send_item(ACT_READ, PATTERN_B);
        w = PATTERN_A;
        w[3][31] = ~w[3][31];
        send_item(ACT_READ, w);
        send_item(ACT_READ, PATTERN_B);
        // restart mid-tap
        send_item(ACT_START, {4{WORD_ZERO}});
        send_item(ACT_READ, PATTERN_A);
        send_item(ACT_READ, PATTERN_B);
        send_item(ACT_READ, PATTERN_A);
        send_item(ACT_READ, PATTERN_B);
        wait_drained();
    endtask

    task automatic test_window_edges();
        t_window_shape     plan [3][5];
        logic [4:0][15:0] masks;
        plan = '{'{WIN_EMPTY, WIN_TOP_ONLY, WIN_BOTTOM_ONLY, WIN_FULL, WIN_EMPTY},
                 '{WIN_FULL, WIN_SPAN, WIN_SCATTER, WIN_EMPTY, WIN_TOP_ONLY},
                 '{WIN_TOP_ONLY, WIN_BOTTOM_ONLY, WIN_FULL, WIN_SPAN, WIN_SCATTER}};
        for (int i = 0; i < 3; i++) begin
            for (int g = 0; g < SWEEP_GROUPS; g++) begin
                masks[g] = shape_mask(plan[i][g]);
            end
            sweep_training(masks, SWEEP_GROUPS * SWEEP_TAPS);
        end
        wait_drained();
    endtask

    task automatic test_output_stall();
        logic [4:0][15:0] masks;
        for (int g = 0; g < SWEEP_GROUPS; g++) begin
            masks[g] = shape_mask(WIN_SPAN);
        end
        sender_steady = 1'b1;
        hold_output   = 1'b1;
        sweep_training(masks, 20);
        sender_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_training();
        logic [4:0][15:0] masks;
        int               stop_taps;
        while (items_sent < TARGET_ITEMS) begin
            for (int g = 0; g < SWEEP_GROUPS; g++) begin
                masks[g] = shape_mask(t_window_shape'($urandom_range(0, 5)));
            end
            sender_steady   = ($urandom_range(0, 4) == 0);
            receiver_steady = ($urandom_range(0, 4) == 0);
            stop_taps = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 79))
                                                    : SWEEP_GROUPS * SWEEP_TAPS;
            if (stop_taps > (TARGET_ITEMS - items_sent) / TAP_READS + 1) begin
                stop_taps = (TARGET_ITEMS - items_sent) / TAP_READS + 1;
            end
            sweep_training(masks, stop_taps);
            repeat ($urandom_range(0, 3)) begin
                send_item(ACT_READ, ($urandom_range(0, 1) == 1) ? random_words() : PATTERN_A);
            end
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_output) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end
            stall = draw_gap(receiver_steady);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (tap_results_due.size() == 0) begin
                $error("result transfer with nothing due: kind %0d group %0d tap %0d",
                       o_kind, o_group, o_tap_value);
                failures++;
            end else begin
                due = tap_results_due.pop_front();
                check_field("kind", int'(due.kind), int'(o_kind));
                check_field("group", int'(due.group), int'(o_group));
                check_field("tap_value", int'(due.tap_value), int'(o_tap_value));
                check_field("read_address", int'(due.read_address), int'(o_read_address));
                check_field("window_empty", int'(due.window_empty), int'(o_window_empty));
                check_field("last", int'(due.last), int'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ignored_reads();
        test_read_patterns();
        test_window_edges();
        test_output_stall();
        test_random_training();
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
